[hw/rtl/lepton_overlap_removal_defines.svh]
// Assertion helpers for the overlap removal block
`ifndef LEPTON_OVERLAP_REMOVAL_DEFINES_SVH
`define LEPTON_OVERLAP_REMOVAL_DEFINES_SVH

// cons must hold in every cycle in which ante holds
`define LOR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lepton_overlap_removal: implication violated");

// cond must never hold
`define LOR_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("lepton_overlap_removal: forbidden condition");

`endif

[hw/rtl/lor_pkg.sv]
package lor_pkg;

  localparam int unsigned LOR_MAX_LEPTONS = 32;
  localparam int unsigned LOR_SLOT_W      = 7;
  localparam int unsigned LOR_RESULT_CAP  = 32;
  localparam int unsigned LOR_IDX_W       = 5;
  localparam int unsigned LOR_Q_DEPTH     = 4;

  typedef struct packed {
    logic                  store;
    logic                  eoe;
    logic [LOR_SLOT_W-1:0] slot;
    logic                  is_muon;
    logic                  has_track;
    logic [31:0]           track_id;
    logic [31:0]           pt_mev;
  } lor_item_t;

  typedef struct packed {
    logic        is_muon;
    logic        has_track;
    logic [31:0] track_id;
    logic [31:0] pt_mev;
  } lor_lep_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lor_q_stat_t;

  typedef struct packed {
    logic loading;
    logic emitting;
  } lor_bk_stat_t;

  typedef enum logic [1:0] {
    BK_LOAD,
    BK_EVAL,
    BK_EMIT_RD,
    BK_EMIT_WR
  } lor_bk_state_t;

endpackage

[hw/rtl/lepton_overlap_removal.sv]
// Channel  Handshake            Payload
// in       in_valid/in_ready    is_muon, has_track, track_id, pt_mev, end_of_event
// out      out_valid/out_ready  lepton_index, kind_out, removed, overflowed, last_result
//
// Loads enter one item per cycle through a short queue, unless it is full, while the
// evaluator is loading. An event of n >= 2 stored leptons is then evaluated by pairwise
// compare (one pair per cycle over the two read ports of the lepton memory), then each
// result is read and sent; the queue keeps taking items meanwhile until it fills.
// rst_n is synchronous, active low; it clears control state only, no memory sweep.
// A stalled out_ready holds the current result and pauses the result loop.
`include "lepton_overlap_removal_defines.svh"

module lepton_overlap_removal
  import lor_pkg::*;
#(
  parameter int unsigned MAX_LEPTONS = LOR_MAX_LEPTONS,
  parameter int unsigned Q_DEPTH     = LOR_Q_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_is_muon,
  input  logic                 in_has_track,
  input  logic [31:0]          in_track_id,
  input  logic [31:0]          in_pt_mev,
  input  logic                 in_end_of_event,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [LOR_IDX_W-1:0] out_lepton_index,
  output logic                 out_kind_out,
  output logic                 out_removed,
  output logic                 out_overflowed,
  output logic                 out_last_result
);

  lor_q_stat_t  q_stat;
  lor_bk_stat_t bk_stat;
  lor_item_t    push_item, pop_item;
  logic         q_push, q_pop;

  lor_front #(
    .MAX_LEPTONS(MAX_LEPTONS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_is_muon      (in_is_muon),
    .in_has_track    (in_has_track),
    .in_track_id     (in_track_id),
    .in_pt_mev       (in_pt_mev),
    .in_end_of_event (in_end_of_event),
    .q_stat          (q_stat),
    .q_push          (q_push),
    .q_item          (push_item)
  );

  lor_queue #(
    .DEPTH(Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .stat      (q_stat)
  );

  lor_back #(
    .MAX_LEPTONS(MAX_LEPTONS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .q_pop            (q_pop),
    .q_item           (pop_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_lepton_index (out_lepton_index),
    .out_kind_out     (out_kind_out),
    .out_removed      (out_removed),
    .out_overflowed   (out_overflowed),
    .out_last_result  (out_last_result),
    .stat             (bk_stat)
  );

  `LOR_ASSERT_NEVER(a_q_full_empty, q_stat.full && q_stat.empty)
  `LOR_ASSERT_IMP(a_out_from_emit, $rose(out_valid), $past(bk_stat.emitting))
  `LOR_ASSERT_IMP(a_eval_on_eoe, $fell(bk_stat.loading), $past(q_pop && pop_item.eoe))

endmodule

[hw/rtl/lor_front.sv]
module lor_front
  import lor_pkg::*;
#(
  parameter int unsigned MAX_LEPTONS = LOR_MAX_LEPTONS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_is_muon,
  input  logic        in_has_track,
  input  logic [31:0] in_track_id,
  input  logic [31:0] in_pt_mev,
  input  logic        in_end_of_event,
  input  lor_q_stat_t q_stat,
  output logic        q_push,
  output lor_item_t   q_item
);

  localparam int unsigned CNT_W = $clog2(MAX_LEPTONS + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             keep;

  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && in_ready;
  assign keep     = (cnt_r < CNT_W'(MAX_LEPTONS));

  always_comb begin
    q_item.store     = keep;
    q_item.eoe       = in_end_of_event;
    q_item.slot      = LOR_SLOT_W'(cnt_r);
    q_item.is_muon   = in_is_muon;
    q_item.has_track = in_has_track;
    q_item.track_id  = in_track_id;
    q_item.pt_mev    = in_pt_mev;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push) begin
      if (in_end_of_event) begin
        cnt_nxt = '0;
      end else if (keep) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[hw/rtl/lor_queue.sv]
module lor_queue
  import lor_pkg::*;
#(
  parameter int unsigned DEPTH = LOR_Q_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  lor_item_t   push_item,
  input  logic        pop,
  output lor_item_t   pop_item,
  output lor_q_stat_t stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lor_item_t        slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_item   = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[hw/rtl/lor_back.sv]
module lor_back
  import lor_pkg::*;
#(
  parameter int unsigned MAX_LEPTONS = LOR_MAX_LEPTONS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lor_q_stat_t          q_stat,
  output logic                 q_pop,
  input  lor_item_t            q_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [LOR_IDX_W-1:0] out_lepton_index,
  output logic                 out_kind_out,
  output logic                 out_removed,
  output logic                 out_overflowed,
  output logic                 out_last_result,
  output lor_bk_stat_t         stat
);

  localparam int unsigned ADDR_W = $clog2(MAX_LEPTONS);
  localparam int unsigned CNT_W  = $clog2(MAX_LEPTONS + 1);

  lor_lep_t mem [MAX_LEPTONS];
  lor_lep_t rd_a_r, rd_b_r;

  logic [ADDR_W-1:0] addr_a, addr_b;
  logic              wr_en;
  lor_lep_t          wr_data;

  lor_bk_state_t      state_r, state_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic               ovf_r, ovf_nxt;
  logic [CNT_W-1:0]   a_r, a_nxt;
  logic [CNT_W-1:0]   b_r, b_nxt;
  logic               iss_r, iss_nxt;
  logic               p1_vld_r, p1_vld_nxt;
  logic [ADDR_W-1:0]  p1_a_r, p1_a_nxt;
  logic [ADDR_W-1:0]  p1_b_r, p1_b_nxt;
  logic [MAX_LEPTONS-1:0] drop_r, drop_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [LOR_IDX_W-1:0] idx_r, idx_nxt;
  logic                 kind_r, kind_nxt;
  logic                 rem_r, rem_nxt;
  logic                 oflw_r, oflw_nxt;
  logic                 last_r, last_nxt;

  logic                  match, same_kind, drop_a, drop_b;
  logic [CNT_W-1:0]      n_in;
  logic [LOR_SLOT_W-1:0] n_ext, k_ext, emit_n;
  logic                  cap_hit, k_last;

  assign wr_data.is_muon   = q_item.is_muon;
  assign wr_data.has_track = q_item.has_track;
  assign wr_data.track_id  = q_item.track_id;
  assign wr_data.pt_mev    = q_item.pt_mev;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[q_item.slot[ADDR_W-1:0]] <= wr_data;
    end
    rd_a_r <= mem[addr_a];
    rd_b_r <= mem[addr_b];
  end

  assign match     = rd_a_r.has_track && rd_b_r.has_track &&
                     (rd_a_r.track_id == rd_b_r.track_id);
  assign same_kind = (rd_a_r.is_muon == rd_b_r.is_muon);
  assign drop_a    = same_kind ? (rd_a_r.pt_mev < rd_b_r.pt_mev) : !rd_a_r.is_muon;
  assign drop_b    = !drop_a;

  assign n_in    = q_item.store ? CNT_W'(q_item.slot) + CNT_W'(1) : CNT_W'(q_item.slot);
  assign n_ext   = LOR_SLOT_W'(n_r);
  assign k_ext   = LOR_SLOT_W'(k_r);
  assign cap_hit = (n_ext > LOR_SLOT_W'(LOR_RESULT_CAP));
  assign emit_n  = cap_hit ? LOR_SLOT_W'(LOR_RESULT_CAP) : n_ext;
  assign k_last  = ((k_ext + LOR_SLOT_W'(1)) == emit_n);

  assign addr_a = (state_r == BK_EVAL) ? a_r[ADDR_W-1:0] : k_r[ADDR_W-1:0];
  assign addr_b = b_r[ADDR_W-1:0];

  assign q_pop         = (state_r == BK_LOAD) && !q_stat.empty;
  assign wr_en         = q_pop && q_item.store;
  assign stat.loading  = (state_r == BK_LOAD);
  assign stat.emitting = (state_r == BK_EMIT_WR);

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    ovf_nxt       = ovf_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    iss_nxt       = iss_r;
    p1_vld_nxt    = 1'b0;
    p1_a_nxt      = p1_a_r;
    p1_b_nxt      = p1_b_r;
    drop_nxt      = drop_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_ready;
    idx_nxt       = idx_r;
    kind_nxt      = kind_r;
    rem_nxt       = rem_r;
    oflw_nxt      = oflw_r;
    last_nxt      = last_r;

    if (p1_vld_r && match) begin
      if (drop_a) begin
        drop_nxt[p1_a_r] = 1'b1;
      end
      if (drop_b) begin
        drop_nxt[p1_b_r] = 1'b1;
      end
    end

    unique case (state_r)
      BK_LOAD: begin
        if (q_pop) begin
          if (!q_item.store) begin
            ovf_nxt = 1'b1;
          end
          if (q_item.eoe) begin
            n_nxt     = n_in;
            a_nxt     = '0;
            b_nxt     = CNT_W'(1);
            iss_nxt   = (n_in >= CNT_W'(2));
            drop_nxt  = '0;
            state_nxt = BK_EVAL;
          end
        end
      end
      BK_EVAL: begin
        if (iss_r) begin
          p1_vld_nxt = 1'b1;
          p1_a_nxt   = a_r[ADDR_W-1:0];
          p1_b_nxt   = b_r[ADDR_W-1:0];
          if (b_r == n_r - CNT_W'(1)) begin
            a_nxt = a_r + CNT_W'(1);
            b_nxt = a_r + CNT_W'(2);
            if (a_r + CNT_W'(2) == n_r) begin
              iss_nxt = 1'b0;
            end
          end else begin
            b_nxt = b_r + CNT_W'(1);
          end
        end else if (!p1_vld_r) begin
          k_nxt     = '0;
          state_nxt = BK_EMIT_RD;
        end
      end
      BK_EMIT_RD: begin
        state_nxt = BK_EMIT_WR;
      end
      BK_EMIT_WR: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          idx_nxt       = LOR_IDX_W'(k_r);
          kind_nxt      = rd_a_r.is_muon;
          rem_nxt       = drop_r[k_r[ADDR_W-1:0]];
          oflw_nxt      = ovf_r || cap_hit;
          last_nxt      = k_last;
          if (k_last) begin
            ovf_nxt   = 1'b0;
            state_nxt = BK_LOAD;
          end else begin
            k_nxt     = k_r + CNT_W'(1);
            state_nxt = BK_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = BK_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_LOAD;
      ovf_r       <= 1'b0;
      iss_r       <= 1'b0;
      p1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ovf_r       <= ovf_nxt;
      iss_r       <= iss_nxt;
      p1_vld_r    <= p1_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    p1_a_r <= p1_a_nxt;
    p1_b_r <= p1_b_nxt;
    drop_r <= drop_nxt;
    k_r    <= k_nxt;
    idx_r  <= idx_nxt;
    kind_r <= kind_nxt;
    rem_r  <= rem_nxt;
    oflw_r <= oflw_nxt;
    last_r <= last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_lepton_index = idx_r;
  assign out_kind_out     = kind_r;
  assign out_removed      = rem_r;
  assign out_overflowed   = oflw_r;
  assign out_last_result  = last_r;

endmodule
